// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- rtl/core/rrae_pkg.sv -----
// ---------------------------------------------------------------------------
// rrae_pkg
// Shared types and constants for the register-format execute unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package rrae_pkg;
    localparam int unsigned XLEN      = 32;
    localparam int unsigned PC_W      = 30;
    localparam int unsigned REG_AW    = 5;
    localparam int unsigned REG_DEPTH = 32;

    typedef enum logic [5:0] {
        FN_SLL  = 6'h00, FN_SRL  = 6'h02, FN_SRA  = 6'h03, FN_SLLV = 6'h04,
        FN_SRLV = 6'h06, FN_SRAV = 6'h07, FN_JR   = 6'h08, FN_JALR = 6'h09,
        FN_MFHI = 6'h10, FN_MTHI = 6'h11, FN_MFLO = 6'h12, FN_MTLO = 6'h13,
        FN_MULT = 6'h18, FN_MULTU = 6'h19, FN_DIV = 6'h1A, FN_DIVU = 6'h1B,
        FN_ADD  = 6'h20, FN_ADDU = 6'h21, FN_SUB  = 6'h22, FN_SUBU = 6'h23,
        FN_AND  = 6'h24, FN_OR   = 6'h25, FN_XOR  = 6'h26, FN_SLT  = 6'h2A,
        FN_SLTU = 6'h2B
    } t_fn;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ARITH = 2'd1,
        ST_ALIGN = 2'd2,
        ST_INVAL = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_JALR, S_OUT
    } t_state;

    // Start request to the iterative multiply/divide unit.
    typedef struct packed {
        logic start;
        logic is_div;
        logic sgn;
    } t_md_req;

    // Completion report from the multiply/divide unit.
    typedef struct packed {
        logic             done;
        logic [XLEN-1:0]  hi;
        logic [XLEN-1:0]  lo;
    } t_md_rsp;
endpackage

// ----- rtl/core/risc_register_alu_execute.sv -----
// ALU, shift, move and JR operations go from READ through EXEC to OUT; JALR
// adds a second register file read, and multiply and divide wait on the
// iterative unit (a divide with a zero divisor skips it).
// One request at a time; the next is taken once the result has been taken.
// The 32-entry register file is cleared by a sweep after reset, during
// which no request is accepted; HI and LO reset to zero.
// ---------------------------------------------------------------------------
// risc_register_alu_execute
// Register-format execute unit with register file, HI/LO and iterative MD.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module risc_register_alu_execute
    import rrae_pkg::*;
#(
    parameter int unsigned P_REG_DEPTH = REG_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [XLEN-1:0]   i_instruction,
    input  logic [PC_W-1:0]   i_current_next_pc,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_status,
    output logic [PC_W-1:0]   o_new_next_pc,
    output logic              o_write_enable,
    output logic [REG_AW-1:0] o_write_register,
    output logic [XLEN-1:0]   o_write_value
);
    localparam int unsigned AW = $clog2(P_REG_DEPTH);

    // The request flows IDLE -> READ (register file read) -> EXEC, then either
    // straight to OUT or through the multiply/divide unit or the JALR
    // re-read, and OUT holds the result until the consumer takes it.
    t_state r_state, n_state;

    // Clear sweep after reset.
    logic          r_clr, n_clr;
    logic [AW-1:0] r_clr_idx, n_clr_idx;

    // Captured request.
    logic [XLEN-1:0] r_ins, n_ins;
    logic [PC_W-1:0] r_npc, n_npc;

    // Result registers.
    logic [1:0]        r_status, n_status;
    logic [PC_W-1:0]   r_next, n_next;
    logic              r_we, n_we;
    logic [REG_AW-1:0] r_rd, n_rd;
    logic [XLEN-1:0]   r_val, n_val;

    logic [XLEN-1:0] r_hi, n_hi;
    logic [XLEN-1:0] r_lo, n_lo;

    // Register file ports.
    logic            rf_we;
    logic [AW-1:0]   rf_waddr, rf_ra, rf_rb;
    logic [XLEN-1:0] rf_wdata, rf_a, rf_b;

    t_md_req md_req;
    t_md_rsp md_rsp;

    logic [4:0] f_rs, f_rt, f_rd, f_sa, sh;
    logic [5:0] fn;
    logic [XLEN-1:0] a, b, addv, subv;
    logic [PC_W-1:0] inc_pc;

    assign f_rs = r_ins[25:21];
    assign f_rt = r_ins[20:16];
    assign f_rd = r_ins[15:11];
    assign f_sa = r_ins[10:6];
    assign fn   = r_ins[5:0];
    assign a    = rf_a;
    assign b    = rf_b;
    assign addv = a + b;
    assign subv = a - b;
    assign inc_pc = r_npc + 1'b1;

    rrae_regfile #(
        .P_DEPTH (P_REG_DEPTH),
        .P_WIDTH (XLEN)
    ) u_rf (
        .i_clk     (i_clk),
        .i_we      (rf_we),
        .i_waddr   (rf_waddr),
        .i_wdata   (rf_wdata),
        .i_raddr_a (rf_ra),
        .i_raddr_b (rf_rb),
        .o_rdata_a (rf_a),
        .o_rdata_b (rf_b)
    );

    rrae_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .i_a     (a),
        .i_b     (b),
        .o_rsp   (md_rsp)
    );

    assign o_stall = !(r_state == S_IDLE && !r_clr);

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_clr_idx = r_clr_idx;
        n_ins     = r_ins;
        n_npc     = r_npc;
        n_status  = r_status;
        n_next    = r_next;
        n_we      = r_we;
        n_rd      = r_rd;
        n_val     = r_val;
        n_hi      = r_hi;
        n_lo      = r_lo;
        rf_we     = 1'b0;
        rf_waddr  = AW'(f_rd);
        rf_wdata  = r_val;
        rf_ra     = AW'(f_rs);
        rf_rb     = AW'(f_rt);
        md_req    = '0;
        sh        = f_sa;

        if (r_clr) begin
            rf_we    = 1'b1;
            rf_waddr = r_clr_idx;
            rf_wdata = '0;
            n_clr_idx = r_clr_idx + 1'b1;
            if (r_clr_idx == AW'(P_REG_DEPTH - 1)) begin
                n_clr = 1'b0;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid && !r_clr) begin
                    n_ins   = i_instruction;
                    n_npc   = i_current_next_pc;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                // Addresses from the captured word; data arrive next cycle.
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_status = ST_OK;
                n_next   = inc_pc;
                n_we     = 1'b0;
                n_rd     = f_rd;
                n_val    = '0;
                n_state  = S_OUT;
                if (fn[2]) begin
                    sh = a[4:0];
                end
                unique case (fn)
                    FN_ADDU: begin n_we = 1'b1; n_val = addv; end
                    FN_SUBU: begin n_we = 1'b1; n_val = subv; end
                    FN_ADD: begin
                        if (~(a[31] ^ b[31]) & (a[31] ^ addv[31])) n_status = ST_ARITH;
                        else begin n_we = 1'b1; n_val = addv; end
                    end
                    FN_SUB: begin
                        if ((a[31] ^ b[31]) & (a[31] ^ subv[31])) n_status = ST_ARITH;
                        else begin n_we = 1'b1; n_val = subv; end
                    end
                    FN_AND:  begin n_we = 1'b1; n_val = a & b; end
                    FN_OR:   begin n_we = 1'b1; n_val = a | b; end
                    FN_XOR:  begin n_we = 1'b1; n_val = a ^ b; end
                    FN_SLT:  begin n_we = 1'b1; n_val = XLEN'($signed(a) < $signed(b)); end
                    FN_SLTU: begin n_we = 1'b1; n_val = XLEN'(a < b); end
                    FN_SLL, FN_SLLV: begin n_we = 1'b1; n_val = b << sh; end
                    FN_SRL, FN_SRLV: begin n_we = 1'b1; n_val = b >> sh; end
                    FN_SRA, FN_SRAV: begin n_we = 1'b1; n_val = $unsigned($signed(b) >>> sh); end
                    FN_MFHI: begin n_we = 1'b1; n_val = r_hi; end
                    FN_MFLO: begin n_we = 1'b1; n_val = r_lo; end
                    FN_MTHI: n_hi = a;
                    FN_MTLO: n_lo = a;
                    FN_MULT, FN_MULTU: begin
                        md_req.start  = 1'b1;
                        md_req.is_div = 1'b0;
                        md_req.sgn    = (fn == FN_MULT);
                        n_state = S_MUL;
                    end
                    FN_DIV, FN_DIVU: begin
                        if (b == '0) n_status = ST_ARITH;
                        else begin
                            md_req.start  = 1'b1;
                            md_req.is_div = 1'b1;
                            md_req.sgn    = (fn == FN_DIV);
                            n_state = S_DIV;
                        end
                    end
                    FN_JR: begin
                        if (a[1:0] != 2'b00) n_status = ST_ALIGN;
                        else n_next = a[XLEN-1:2];
                    end
                    FN_JALR: begin
                        // Link write now; the JALR state forwards the link value when rd == rs.
                        n_we     = 1'b1;
                        n_val    = {inc_pc, 2'b00};
                        rf_we    = 1'b1;
                        rf_wdata = {inc_pc, 2'b00};
                        n_state  = S_JALR;
                    end
                    default: n_status = ST_INVAL;
                endcase
                if (n_status != ST_OK) begin
                    n_next = r_npc;
                end
            end
            S_MUL, S_DIV: begin
                if (md_rsp.done) begin
                    n_hi    = md_rsp.hi;
                    n_lo    = md_rsp.lo;
                    n_state = S_OUT;
                end
            end
            S_JALR: begin
                // Read issued during the write cycle returns old data; the
                // written value is forwarded when rd equals rs.
                if (f_rd == f_rs) begin
                    n_next = r_val[XLEN-1:2];
                end else if (a[1:0] != 2'b00) begin
                    n_status = ST_ALIGN;
                    n_next   = r_npc;
                end else begin
                    n_next = a[XLEN-1:2];
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    if (r_we && fn != FN_JALR) begin
                        rf_we = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_clr     <= 1'b1;
            r_clr_idx <= '0;
            r_hi      <= '0;
            r_lo      <= '0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_clr_idx <= n_clr_idx;
            r_hi      <= n_hi;
            r_lo      <= n_lo;
        end
        r_ins    <= n_ins;
        r_npc    <= n_npc;
        r_status <= n_status;
        r_next   <= n_next;
        r_we     <= n_we;
        r_rd     <= n_rd;
        r_val    <= n_val;
    end

    assign o_valid          = (r_state == S_OUT);
    assign o_status         = r_status;
    assign o_new_next_pc    = r_next;
    assign o_write_enable   = r_we;
    assign o_write_register = r_we ? r_rd : '0;
    assign o_write_value    = r_we ? r_val : '0;

    `ASSERT_IMPL(a_no_accept_in_clear, i_clk, i_rst_n, r_clr, o_stall, "request accepted during clear")
    `ASSERT_IMPL(a_err_no_write, i_clk, i_rst_n, o_valid && o_status != ST_OK && o_status != ST_ALIGN, !o_write_enable, "write on error")
    `ASSERT_NEXT(a_md_done_state, i_clk, i_rst_n, md_req.start, r_state == S_MUL || r_state == S_DIV, "md start without wait state")
    `ASSERT_IMPL(a_busy_stall, i_clk, i_rst_n, r_state != S_IDLE, o_stall, "ready while busy")
endmodule

// ----- rtl/core/rrae_regfile.sv -----
// ---------------------------------------------------------------------------
// rrae_regfile
// Register file: one write port and two registered read ports.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module rrae_regfile
    import rrae_pkg::*;
#(
    parameter int unsigned P_DEPTH = REG_DEPTH,
    parameter int unsigned P_WIDTH = XLEN
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    input  logic [$clog2(P_DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(P_DEPTH)-1:0] i_raddr_b,
    output logic [P_WIDTH-1:0]         o_rdata_a,
    output logic [P_WIDTH-1:0]         o_rdata_b
);
    logic [P_WIDTH-1:0] r_mem [P_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

// ----- rtl/core/rrae_muldiv.sv -----
// ---------------------------------------------------------------------------
// rrae_muldiv
// Iterative shift-add multiplier and restoring divider, one bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module rrae_muldiv
    import rrae_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_md_req         i_req,
    input  logic [XLEN-1:0] i_a,
    input  logic [XLEN-1:0] i_b,
    output t_md_rsp         o_rsp
);
    localparam int unsigned CW = $clog2(XLEN + 1);

    logic            r_busy, n_busy;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_div, n_div;
    logic            r_negq, n_negq;
    logic            r_negr, n_negr;
    logic [XLEN-1:0] r_acc, n_acc;   // product high / remainder
    logic [XLEN-1:0] r_q, n_q;       // product low / quotient
    logic [XLEN-1:0] r_d, n_d;       // multiplicand / divisor
    logic            r_done, n_done;

    logic [XLEN-1:0] ma, mb;
    logic [XLEN:0]   sum;
    logic [XLEN:0]   trial;
    logic [2*XLEN-1:0] prod;

    always_comb begin
        ma = (i_req.sgn && i_a[XLEN-1]) ? (~i_a + 1'b1) : i_a;
        mb = (i_req.sgn && i_b[XLEN-1]) ? (~i_b + 1'b1) : i_b;
        sum   = {1'b0, r_acc} + {1'b0, (r_q[0] ? r_d : '0)};
        trial = {r_acc, r_q[XLEN-1]} - {1'b0, r_d};
        prod  = {r_acc, r_q};
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_div  = r_div;
        n_negq = r_negq;
        n_negr = r_negr;
        n_acc  = r_acc;
        n_q    = r_q;
        n_d    = r_d;
        n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(XLEN);
            n_div  = i_req.is_div;
            n_negq = i_req.sgn && (i_a[XLEN-1] ^ i_b[XLEN-1]);
            n_negr = i_req.sgn && i_a[XLEN-1];
            n_acc  = '0;
            n_q    = ma;
            n_d    = mb;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                if (r_div) begin
                    n_q   = r_negq ? (~r_q + 1'b1) : r_q;
                    n_acc = r_negr ? (~r_acc + 1'b1) : r_acc;
                end else if (r_negq) begin
                    {n_acc, n_q} = ~prod + 1'b1;
                end
            end else begin
                n_cnt = r_cnt - 1'b1;
                if (r_div) begin
                    if (!trial[XLEN]) begin
                        n_acc = trial[XLEN-1:0];
                        n_q   = {r_q[XLEN-2:0], 1'b1};
                    end else begin
                        n_acc = {r_acc[XLEN-2:0], r_q[XLEN-1]};
                        n_q   = {r_q[XLEN-2:0], 1'b0};
                    end
                end else begin
                    {n_acc, n_q} = {sum, r_q[XLEN-1:1]};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_div  <= n_div;
        r_negq <= n_negq;
        r_negr <= n_negr;
        r_acc  <= n_acc;
        r_q    <= n_q;
        r_d    <= n_d;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.hi   = r_acc;
    assign o_rsp.lo   = r_q;
endmodule
